[design/sqmin_pkg.sv]
`timescale 1ns / 1ps
package sqmin_pkg;

	localparam int PIX_W = 16;
	localparam int OX_W  = 11;
	localparam int OY_W  = 12;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic accept;
		logic row_init;
		logic row_step;
		logic row_wr;
		logic col_start;
		logic col_init;
		logic col_rd;
		logic col_acc;
		logic emit;
		logic finish;
	} sqmin_cmd_t;

	typedef struct packed {
		logic hx_now;
		logic hy;
		logic cnt_zero;
		logic x_done;
		logic rd_last;
		logic emit_last;
		logic out_free;
	} sqmin_stat_t;

endpackage

[design/sqmin_if.sv]
`timescale 1ns / 1ps
interface sqmin_pix_if;
	import sqmin_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sqmin_res_if;
	import sqmin_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] min_value;
	logic [OX_W-1:0]  out_x;
	logic [OY_W-1:0]  out_y;
	logic             last;
	modport source (output valid, output min_value, output out_x, output out_y,
		output last, input ready);
	modport sink   (input valid, input min_value, input out_x, input out_y,
		input last, output ready);
endinterface

[design/sqmin_ctrl.sv]
`timescale 1ns / 1ps
module sqmin_ctrl
	import sqmin_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sqmin_stat_t stat,
	output sqmin_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_ROW_INIT, S_ROW_STEP, S_ROW_WR, S_COL_START,
		S_COL_INIT, S_COL_RD, S_COL_ACC, S_EMIT, S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:      cmd.accept    = in_valid;
			S_ROW_INIT:  cmd.row_init  = 1'b1;
			S_ROW_STEP:  cmd.row_step  = 1'b1;
			S_ROW_WR:    cmd.row_wr    = 1'b1;
			S_COL_START: cmd.col_start = 1'b1;
			S_COL_INIT:  cmd.col_init  = 1'b1;
			S_COL_RD:    cmd.col_rd    = 1'b1;
			S_COL_ACC:   cmd.col_acc   = 1'b1;
			S_EMIT:      cmd.emit      = stat.out_free;
			S_FINISH:    cmd.finish    = 1'b1;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= stat.hx_now ? S_ROW_INIT : S_FINISH;
				end
				S_ROW_INIT: state_q <= S_ROW_STEP;
				S_ROW_STEP: begin
					if (stat.cnt_zero) state_q <= S_ROW_WR;
				end
				S_ROW_WR: begin
					if (!stat.x_done) state_q <= S_ROW_INIT;
					else state_q <= stat.hy ? S_COL_START : S_FINISH;
				end
				S_COL_START: state_q <= S_COL_INIT;
				S_COL_INIT:  state_q <= S_COL_RD;
				S_COL_RD:    state_q <= S_COL_ACC;
				S_COL_ACC:   state_q <= stat.rd_last ? S_EMIT : S_COL_RD;
				S_EMIT: begin
					if (stat.out_free) state_q <= stat.emit_last ? S_FINISH : S_COL_INIT;
				end
				S_FINISH: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[design/sqmin_dp.sv]
`timescale 1ns / 1ps
module sqmin_dp
	import sqmin_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	parameter int MAX_RADIUS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sqmin_cmd_t                    cmd,
	output sqmin_stat_t                   stat,
	input  logic                          clr,
	input  logic [PIX_W-1:0]              pixel_in,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wm1,
	input  logic [$clog2(MAX_HEIGHT)-1:0] hm1,
	input  logic [2:0]                    rad,
	sqmin_res_if.source                   results
);

	localparam int SPAN = 2 * MAX_RADIUS + 1;
	localparam int SW   = $clog2(SPAN);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int HW   = $clog2(MAX_HEIGHT);
	localparam int AW   = $clog2(SPAN * MAX_WIDTH);

	logic [CW-1:0]    cx_q, xlo_q, xhi_q, x_q;
	logic [HW-1:0]    cy_q, ylo_q, yhi_q, y_q;
	logic [SW-1:0]    wptr_q, rptr_q, slot_q, cnt_q;
	logic             hy_q, rd_last_q;
	logic [PIX_W-1:0] acc_q, rdata_q;
	logic [PIX_W-1:0] win_q [SPAN];
	logic [PIX_W-1:0] mem_q [SPAN * MAX_WIDTH];

	logic [CW-1:0] rc, xlo_n, xhi_n, wlo, whi;
	logic [HW-1:0] rr, ylo_n, yhi_n, clo, chi;
	logic [CW:0]   wsum;
	logic [HW:0]   csum;
	logic          x_ge, x_end, y_ge, y_end;
	logic [SW-1:0] row_start, col_start;
	logic [AW-1:0] waddr, raddr;

	function automatic logic [SW-1:0] wrap_sub(logic [SW-1:0] p, logic [SW-1:0] d);
		return (p >= d) ? p - d : p + SW'(SPAN) - d;
	endfunction

	function automatic logic [SW-1:0] wrap_inc(logic [SW-1:0] p);
		return (p == SW'(SPAN - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rc = CW'(rad);
	assign rr = HW'(rad);

	// range of outputs made ready by the current input
	assign x_end = (cx_q == wm1);
	assign x_ge  = (cx_q >= rc);
	assign xlo_n = x_ge ? cx_q - rc : '0;
	assign xhi_n = x_end ? cx_q : cx_q - rc;
	assign y_end = (cy_q == hm1);
	assign y_ge  = (cy_q >= rr);
	assign ylo_n = y_ge ? cy_q - rr : '0;
	assign yhi_n = y_end ? cy_q : cy_q - rr;

	// clipped window for the row and column passes
	assign wlo  = (x_q >= rc) ? x_q - rc : '0;
	assign wsum = {1'b0, x_q} + {1'b0, rc};
	assign whi  = (wsum > {1'b0, wm1}) ? wm1 : wsum[CW-1:0];
	assign clo  = (y_q >= rr) ? y_q - rr : '0;
	assign csum = {1'b0, y_q} + {1'b0, rr};
	assign chi  = (csum > {1'b0, hm1}) ? hm1 : csum[HW-1:0];

	assign row_start = wrap_sub(wptr_q, SW'(cx_q - wlo));
	assign col_start = wrap_sub(rptr_q, SW'(cy_q - clo));

	assign waddr = AW'(rptr_q) * AW'(MAX_WIDTH) + AW'(x_q);
	assign raddr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(x_q);

	assign stat.hx_now    = x_end | x_ge;
	assign stat.hy        = hy_q;
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.x_done    = (x_q == xhi_q);
	assign stat.rd_last   = rd_last_q;
	assign stat.emit_last = (x_q == xhi_q) && (y_q == yhi_q);
	assign stat.out_free  = !results.valid || results.ready;

	// control: position counters, handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q          <= '0;
			cy_q          <= '0;
			wptr_q        <= '0;
			rptr_q        <= '0;
			hy_q          <= 1'b0;
			rd_last_q     <= 1'b0;
			results.valid <= 1'b0;
		end else begin
			if (cmd.accept) hy_q <= y_end | y_ge;
			if (cmd.col_rd) rd_last_q <= (cnt_q == '0);
			if (cmd.emit) results.valid <= 1'b1;
			else if (results.ready) results.valid <= 1'b0;
			if (clr) begin
				cx_q   <= '0;
				cy_q   <= '0;
				wptr_q <= '0;
				rptr_q <= '0;
			end else if (cmd.finish) begin
				if (x_end) begin
					cx_q   <= '0;
					wptr_q <= '0;
					if (y_end) begin
						cy_q   <= '0;
						rptr_q <= '0;
					end else begin
						cy_q   <= cy_q + 1'b1;
						rptr_q <= wrap_inc(rptr_q);
					end
				end else begin
					cx_q   <= cx_q + 1'b1;
					wptr_q <= wrap_inc(wptr_q);
				end
			end
		end
	end

	// payload: window, iteration registers, accumulator
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			win_q[wptr_q] <= pixel_in;
			xlo_q <= xlo_n;
			xhi_q <= xhi_n;
			ylo_q <= ylo_n;
			yhi_q <= yhi_n;
			x_q   <= xlo_n;
		end
		if (cmd.row_init) begin
			slot_q <= row_start;
			cnt_q  <= SW'(whi - wlo);
			acc_q  <= '1;
		end
		if (cmd.row_step) begin
			if (win_q[slot_q] < acc_q) acc_q <= win_q[slot_q];
			slot_q <= wrap_inc(slot_q);
			cnt_q  <= cnt_q - 1'b1;
		end
		if (cmd.row_wr) x_q <= x_q + 1'b1;
		if (cmd.col_start) begin
			x_q <= xlo_q;
			y_q <= ylo_q;
		end
		if (cmd.col_init) begin
			slot_q <= col_start;
			cnt_q  <= SW'(chi - clo);
			acc_q  <= '1;
		end
		if (cmd.col_rd) begin
			slot_q <= wrap_inc(slot_q);
			cnt_q  <= cnt_q - 1'b1;
		end
		if (cmd.col_acc && rdata_q < acc_q) acc_q <= rdata_q;
		if (cmd.emit) begin
			results.min_value <= acc_q;
			results.out_x     <= OX_W'(x_q);
			results.out_y     <= OY_W'(y_q);
			results.last      <= (x_q == xhi_q) && (y_q == yhi_q);
			if (x_q == xhi_q) begin
				x_q <= xlo_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	// line store of row minima, one write or one read a cycle
	always_ff @(posedge clk) begin
		if (cmd.row_wr) mem_q[waddr] <= acc_q;
		if (cmd.col_rd) rdata_q <= mem_q[raddr];
	end

endmodule

[design/square_minimum_filter_2d_core.sv]
`timescale 1ns / 1ps
// Streaming 2-D minimum filter over a clipped (2r+1)x(2r+1) square window. Pixels enter in
// raster order on the pixels channel, one beat each; result beats carry the minimum and the
// output coordinates, row-major, with last set on the final result of the pixel that made
// them ready. Output (x,y) is released by input column min(x+r,W-1) of row min(y+r,H-1).
// Set width, height and radius over the APB port while the block is idle; any write also
// restarts the image at (0,0). One pixel is handled at a time: a pixel that releases
// nothing goes straight to the finish step; one that releases nx columns of row minima
// but no output rows builds each row minimum tap by tap over the clipped window and
// writes it to the line store; one that also releases ny output rows then reads the
// clipped column of row minima for each of the ny*nx outputs, emitting each result once
// the output register is free. Throughput is bounded by the single minimum unit, walked
// one tap at a time, and the one read port of the row-minimum line store. A result beat
// may wait at the output register while the next pixel is already taken.
module square_minimum_filter_2d_core
	import sqmin_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	parameter int MAX_RADIUS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sqmin_pix_if.sink   pixels,
	sqmin_res_if.source results
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT);

	logic [11:0]   image_width_q;
	logic [12:0]   image_height_q;
	logic [2:0]    window_radius_q;
	logic          cfg_wr;
	logic [CW-1:0] wm1;
	logic [HW-1:0] hm1;
	logic [2:0]    rad;
	sqmin_cmd_t    cmd;
	sqmin_stat_t   stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// register file; every write restarts the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= 12'd1;
			image_height_q  <= 13'd1;
			window_radius_q <= 3'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH:  image_width_q   <= pwdata[11:0];
				REG_HEIGHT: image_height_q  <= pwdata[12:0];
				REG_RADIUS: window_radius_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = {20'd0, image_width_q};
			REG_HEIGHT: prdata = {19'd0, image_height_q};
			REG_RADIUS: prdata = {29'd0, window_radius_q};
			default:    prdata = '0;
		endcase
	end

	// clamp the sizes to what the stores hold
	always_comb begin
		if (image_width_q == '0) wm1 = '0;
		else if (32'(image_width_q) > MAX_WIDTH) wm1 = CW'(MAX_WIDTH - 1);
		else wm1 = CW'(image_width_q - 12'd1);
		if (image_height_q == '0) hm1 = '0;
		else if (32'(image_height_q) > MAX_HEIGHT) hm1 = HW'(MAX_HEIGHT - 1);
		else hm1 = HW'(image_height_q - 13'd1);
		rad = (32'(window_radius_q) > MAX_RADIUS) ? 3'(MAX_RADIUS) : window_radius_q;
	end

	sqmin_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sqmin_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.clr      (cfg_wr),
		.pixel_in (pixels.pixel_in),
		.wm1      (wm1),
		.hm1      (hm1),
		.rad      (rad),
		.results  (results)
	);

`ifndef SYNTHESIS
	// a taken pixel always moves the controller out of its idle state, which drops ready
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready) |=> !pixels.ready)
		else $error("pixel taken while previous one still in flight");

	// more results of the same pixel follow a non-final beat
	a_burst_open: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && !results.last) |=> !pixels.ready)
		else $error("pixel taken inside a result burst");
`endif

endmodule
